/* design/cau_pkg.sv */
// Shared types, constants and helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int QUO_W  = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int VAL_W  = 50;
  localparam int DEN_W  = PROD_W + 1;
  localparam int REM_W  = PROD_W + 2;
  localparam int MAG_W  = PROD_W + 1 + FRAC_W;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      dz;
    logic signed [DATA_W-1:0]  a_re;
    logic signed [DATA_W-1:0]  a_im;
    logic signed [DATA_W-1:0]  b_re;
    logic signed [DATA_W-1:0]  b_im;
  } req_t;

  function automatic logic [DATA_W:0] sat_val(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] lo;
    hi = VAL_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    lo = -hi - VAL_W'(1);
    if (v > hi) begin
      sat_val = {1'b1, hi[DATA_W-1:0]};
    end else if (v < lo) begin
      sat_val = {1'b1, lo[DATA_W-1:0]};
    end else begin
      sat_val = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

endpackage

/* design/cau_front.sv */
// Request intake: classify requests and queue them for the execution pipeline.
module cau_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [127:0]         in_data,
  output logic                 q_valid,
  input  logic                 q_pop,
  output cau_pkg::req_t        q_data
);
  import cau_pkg::*;

  req_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  req_t               req;

  always_comb begin
    req.kind = kind_t'(in_kind);
    req.a_re = in_data[31:0];
    req.a_im = in_data[63:32];
    req.b_re = in_data[95:64];
    req.b_im = in_data[127:96];
    req.dz   = (req.kind == KIND_DIV) && (req.b_re == '0) && (req.b_im == '0);
  end

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

/* design/cau_back.sv */
// Execution pipeline: products, combine, restoring divider stages, saturation.
module cau_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  cau_pkg::req_t q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_data,
  output logic [1:0]    out_user
);
  import cau_pkg::*;

  typedef struct packed {
    logic                      v;
    kind_t                     k;
    logic                      dz;
    logic signed [VAL_W-1:0]   val_re;
    logic signed [VAL_W-1:0]   val_im;
    logic                      ovf_r;
    logic                      ovf_i;
    logic                      neg_r;
    logic                      neg_i;
    logic [DEN_W-1:0]          den;
    logic [REM_W-1:0]          rr;
    logic [REM_W-1:0]          ri;
    logic [QUO_W-1:0]          lr;
    logic [QUO_W-1:0]          li;
    logic [QUO_W-1:0]          qr;
    logic [QUO_W-1:0]          qi;
  } dstg_t;

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  // stage 1: products and sums
  logic                      v1;
  kind_t                     k1;
  logic                      dz1;
  logic signed [PROD_W-1:0]  p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [DATA_W:0]    as_re, as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= q_data.kind;
      dz1  <= q_data.dz;
      p_rr <= q_data.a_re * q_data.b_re;
      p_ii <= q_data.a_im * q_data.b_im;
      p_ri <= q_data.a_re * q_data.b_im;
      p_ir <= q_data.a_im * q_data.b_re;
      p_bb <= q_data.b_re * q_data.b_re;
      p_cc <= q_data.b_im * q_data.b_im;
      if (q_data.kind == KIND_SUB) begin
        as_re <= q_data.a_re - q_data.b_re;
        as_im <= q_data.a_im - q_data.b_im;
      end else begin
        as_re <= q_data.a_re + q_data.b_re;
        as_im <= q_data.a_im + q_data.b_im;
      end
    end
  end

  // stage 2: combine
  logic signed [PROD_W:0]    m_re, m_im, n_re, n_im;
  logic [PROD_W:0]           abs_re, abs_im;
  logic                      v2;
  kind_t                     k2;
  logic                      dz2;
  logic signed [VAL_W-1:0]   val_re2, val_im2;
  logic                      neg_r2, neg_i2;
  logic [MAG_W-1:0]          mag_r2, mag_i2;
  logic [DEN_W-1:0]          den2;

  always_comb begin
    m_re   = p_rr - p_ii;
    m_im   = p_ri + p_ir;
    n_re   = p_rr + p_ii;
    n_im   = p_ir - p_ri;
    abs_re = n_re[PROD_W] ? (PROD_W+1)'(-n_re) : n_re;
    abs_im = n_im[PROD_W] ? (PROD_W+1)'(-n_im) : n_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2     <= k1;
      dz2    <= dz1;
      neg_r2 <= n_re[PROD_W];
      neg_i2 <= n_im[PROD_W];
      mag_r2 <= {abs_re, {FRAC_W{1'b0}}};
      mag_i2 <= {abs_im, {FRAC_W{1'b0}}};
      den2   <= DEN_W'(p_bb) + DEN_W'(p_cc);
      if (k1 == KIND_MUL) begin
        val_re2 <= VAL_W'(m_re >>> FRAC_W);
        val_im2 <= VAL_W'(m_im >>> FRAC_W);
      end else begin
        val_re2 <= VAL_W'(as_re);
        val_im2 <= VAL_W'(as_im);
      end
    end
  end

  // stage 3: quotient range check and divider setup
  dstg_t dst [QUO_W+1];
  logic [MAG_W+QUO_W-1:0] mag_r_w, mag_i_w, den_sh;

  assign mag_r_w = (MAG_W+QUO_W)'(mag_r2);
  assign mag_i_w = (MAG_W+QUO_W)'(mag_i2);
  assign den_sh  = (MAG_W+QUO_W)'({den2, {QUO_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      dst[0].v <= 1'b0;
    end else if (en) begin
      dst[0].v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst[0].k      <= k2;
      dst[0].dz     <= dz2;
      dst[0].val_re <= val_re2;
      dst[0].val_im <= val_im2;
      dst[0].neg_r  <= neg_r2;
      dst[0].neg_i  <= neg_i2;
      dst[0].ovf_r  <= (mag_r_w >= den_sh);
      dst[0].ovf_i  <= (mag_i_w >= den_sh);
      dst[0].den    <= den2;
      dst[0].rr     <= REM_W'(mag_r2[MAG_W-1:QUO_W]);
      dst[0].ri     <= REM_W'(mag_i2[MAG_W-1:QUO_W]);
      dst[0].lr     <= mag_r2[QUO_W-1:0];
      dst[0].li     <= mag_i2[QUO_W-1:0];
      dst[0].qr     <= '0;
      dst[0].qi     <= '0;
    end
  end

  function automatic dstg_t div_step(input dstg_t s);
    dstg_t            n;
    logic [REM_W-1:0] tr;
    logic [REM_W-1:0] ti;
    n  = s;
    tr = {s.rr[REM_W-2:0], s.lr[QUO_W-1]};
    ti = {s.ri[REM_W-2:0], s.li[QUO_W-1]};
    n.lr = {s.lr[QUO_W-2:0], 1'b0};
    n.li = {s.li[QUO_W-2:0], 1'b0};
    if (tr >= REM_W'(s.den)) begin
      n.rr = tr - REM_W'(s.den);
      n.qr = {s.qr[QUO_W-2:0], 1'b1};
    end else begin
      n.rr = tr;
      n.qr = {s.qr[QUO_W-2:0], 1'b0};
    end
    if (ti >= REM_W'(s.den)) begin
      n.ri = ti - REM_W'(s.den);
      n.qi = {s.qi[QUO_W-2:0], 1'b1};
    end else begin
      n.ri = ti;
      n.qi = {s.qi[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dst[g+1].v <= 1'b0;
      end else if (en) begin
        dst[g+1] <= div_step(dst[g]);
      end
    end
  end

  // output stage: select and saturate
  dstg_t                    fin;
  logic signed [VAL_W-1:0]  big;
  logic signed [VAL_W-1:0]  dv_re, dv_im, sel_re, sel_im;
  logic [DATA_W:0]          s_re, s_im;

  always_comb begin
    fin   = dst[QUO_W];
    big   = VAL_W'(64'sd1 <<< (VAL_W - 2));
    dv_re = fin.ovf_r ? (fin.neg_r ? -big : big)
          : (fin.neg_r ? -VAL_W'(fin.qr) : VAL_W'(fin.qr));
    dv_im = fin.ovf_i ? (fin.neg_i ? -big : big)
          : (fin.neg_i ? -VAL_W'(fin.qi) : VAL_W'(fin.qi));
    if (fin.k == KIND_DIV) begin
      sel_re = fin.dz ? '0 : dv_re;
      sel_im = fin.dz ? '0 : dv_im;
    end else begin
      sel_re = fin.val_re;
      sel_im = fin.val_im;
    end
    s_re = sat_val(sel_re);
    s_im = sat_val(sel_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {s_im[DATA_W-1:0], s_re[DATA_W-1:0]};
      out_user <= {fin.dz, s_re[DATA_W] | s_im[DATA_W]};
    end
  end

endmodule

/* design/complex_arithmetic_unit.sv */
// Complex add/subtract/multiply/divide on signed Q16.16 operands, top level.
// Throughput: one request per cycle while the output is not stalled;
// the 32 restoring divider stages and six 32x32 multipliers are fully
// pipelined, so every operation issues back to back.
// A four-entry request queue decouples intake from the execution pipeline.
// Reset (rst, synchronous) empties the queue and clears all pipeline valids.
module complex_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
  input  logic [1:0]    s_axis_tuser,  // kind
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,  // res_re, res_im
  output logic [1:0]    m_axis_tuser   // overflow, div_zero
);
  import cau_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_data;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

/* design/cau_checker.sv */
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_assertions (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic [127:0]  s_axis_tdata,
  input logic [1:0]    s_axis_tuser,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [63:0]   m_axis_tdata,
  input logic [1:0]    m_axis_tuser
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0 && !m_axis_tuser[0])
    else $error("zero-divisor result not cleared");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[31:0] == 32'h7fffffff || m_axis_tdata[31:0] == 32'h80000000 ||
      m_axis_tdata[63:32] == 32'h7fffffff || m_axis_tdata[63:32] == 32'h80000000)
    else $error("overflow flagged without a saturated part");

endmodule

bind complex_arithmetic_unit cau_assertions u_cau_checker (.*);

/* dv/cau_checker.sv */
`timescale 1ns / 1ps
// Checker for the complex arithmetic unit: predicts each result and compares.
module cau_checker
  import cau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending,
  output int           seen_count
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } answer_t;

  answer_t answers_q[$];

  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) begin
      ovf = 1'b1;
      return hi[31:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
    logic signed [127:0] q;
    q = (n < 0) ? -n : n;
    q = q / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic answer_t compute(input kind_t op, input logic [127:0] data);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    answer_t r;
    ar = $signed(data[31:0]);
    ai = $signed(data[63:32]);
    br = $signed(data[95:64]);
    bi = $signed(data[127:96]);
    r = '0;
    case (op)
      KIND_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      KIND_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      KIND_MUL: begin
        re = (ar * br - ai * bi) >>> FRAC_W;
        im = (ar * bi + ai * br) >>> FRAC_W;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          re = trunc_div((ar * br + ai * bi) <<< FRAC_W, den);
          im = trunc_div((ai * br - ar * bi) <<< FRAC_W, den);
        end
      end
    endcase
    r.re = clamp(re, r.ovf);
    r.im = clamp(im, r.ovf);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = answers_q.size();

  initial begin
    fail_count = 0;
    seen_count = 0;
  end

  always @(posedge clk) begin
    answer_t w;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      answers_q.push_back(compute(kind_t'(s_axis_tuser), s_axis_tdata));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_count++;
      if (answers_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], 32'h0);
      end else begin
        w = answers_q.pop_front();
        if (m_axis_tdata[31:0] !== w.re) report("res_re", m_axis_tdata[31:0], w.re);
        if (m_axis_tdata[63:32] !== w.im) report("res_im", m_axis_tdata[63:32], w.im);
        if (m_axis_tuser[0] !== w.ovf) report("overflow", m_axis_tuser[0], w.ovf);
        if (m_axis_tuser[1] !== w.dz) report("div_zero", m_axis_tuser[1], w.dz);
      end
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the complex arithmetic unit testbench.
module tb_top;
  import cau_pkg::*;

  localparam int N_RANDOM = 1880;
  localparam int LIMIT    = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           fail_count;
  int           pending;
  int           seen_count;
  int           cycles = 0;
  int           sent = 0;
  bit           hold_off = 1'b0;

  always #5 clk = ~clk;

  complex_arithmetic_unit dut (.*);

  cau_checker checker_i (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      4, 5: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      6: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input kind_t op, input logic [31:0] ar, input logic [31:0] ai,
                      input logic [31:0] br, input logic [31:0] bi);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bi, br, ai, ar};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_sender();
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      g = pick_gap();
      if (g > 0 && $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    kind_t op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      op = kind_t'(k);
      send(op, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send(op, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send(op, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00020000);
      send(op, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
      send(op, 32'hffffffff, 32'h00000001, 32'h00000001, 32'hffffffff);
    end
    send(KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send(KIND_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 32'h0);
    send(KIND_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0);
    hold_off = 1'b1;
    for (int n = 0; n < N_RANDOM; n++) begin
      op = kind_t'($urandom_range(0, 3));
      if (op == KIND_DIV && $urandom_range(0, 19) == 0) begin
        send(op, pick_part(), pick_part(), 32'h0, 32'h0);
      end else begin
        send(op, pick_part(), pick_part(), pick_part(), pick_part());
      end
      if (n == N_RANDOM / 2) hold_off = 1'b1;
      if ($urandom_range(0, 1) != 0) idle_sender();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d requests covering add, subtract, multiply and divide;", sent);
    $display("checked %0d results including saturation and zero divisors.", seen_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/cau_pkg.sv
design/cau_front.sv
design/cau_back.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
dv/cau_checker.sv
dv/tb_top.sv
